// ----- design/closest_ray_sphere_hit_assert.svh -----
// Assertion macros used by the closest-hit search controller.
// Needs clk and rst_n in the scope of each use.
`ifndef CLOSEST_RAY_SPHERE_HIT_ASSERT_SVH
`define CLOSEST_RAY_SPHERE_HIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CRSH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CRSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CRSH_ASSERT_IMP(lbl, ante, cons)
`define CRSH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/crsh_pkg.sv -----
// Shared types and constants of the ray-sphere closest-hit search.
// No dependencies.
package crsh_pkg;

    localparam int MaxSpheres = 16;
    localparam int SlotW      = 4;
    localparam int CountW     = 5;
    localparam int InDataW    = 296;
    localparam int OutDataW   = 40;
    localparam int AccW       = 136;
    localparam int OpW        = 68;
    localparam int SqRemW     = 72;
    localparam int QW         = 84;
    localparam int DivRemW    = 66;
    localparam int DenW       = 65;
    localparam int StepW      = 7;

    localparam int SlotLo   = 0;
    localparam int PosXLo   = 4;
    localparam int PosYLo   = 36;
    localparam int PosZLo   = 68;
    localparam int DirXLo   = 100;
    localparam int DirYLo   = 132;
    localparam int DirZLo   = 164;
    localparam int RadLo    = 196;
    localparam int VisBit   = 227;
    localparam int TLowLo   = 228;
    localparam int THighLo  = 260;

    typedef enum logic [3:0] {
        MAC_DXDX, MAC_DYDY, MAC_DZDZ,
        MAC_CXDX, MAC_CYDY, MAC_CZDZ,
        MAC_CXCX, MAC_CYCY, MAC_CZCZ,
        MAC_RR, MAC_BB, MAC_AC4
    } mac_op_t;

    localparam logic [3:0] MacLast = 4'(MAC_AC4);

    typedef enum logic [3:0] {
        CMD_NOP, CMD_LOAD_SLOT, CMD_LOAD_RAY, CMD_SEL_SPHERE, CMD_MAC,
        CMD_SQRT, CMD_DIV, CMD_UPDATE, CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        mac_op_t           op;
        logic              root;
        logic [SlotW-1:0]  k;
    } dp_cmd_t;

    typedef struct packed {
        logic vis;
        logic mul_busy;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic a_zero;
        logic disc_neg;
        logic out_full;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SPHERE, ST_SEL, ST_MAC_GO, ST_MAC_WAIT, ST_CHECK,
        ST_SQRT_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_UPD, ST_NEXT, ST_FIN
    } state_t;

endpackage

// ----- design/crsh_ctrl.sv -----
// Controller of the closest-hit search: sequences loads, slot walk and root tests.
// Depends on crsh_pkg and closest_ray_sphere_hit_assert.svh.
`include "closest_ray_sphere_hit_assert.svh"
module crsh_ctrl
    import crsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CountW-1:0] cfg_data,
    output dp_cmd_t           cmd,
    input  dp_stat_t          stat
);

    state_t            state_reg, state_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] k_reg, k_next;
    logic [3:0]        mi_reg, mi_next;
    logic              root_reg, root_next;
    logic [CountW-1:0] n_lim;

    assign cfg_ready = 1'b1;
    assign n_lim = (count_reg > CountW'(MaxSpheres)) ? CountW'(MaxSpheres) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            mi_reg    <= '0;
            root_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            mi_reg    <= mi_next;
            root_reg  <= root_next;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        mi_next    = mi_reg;
        root_next  = root_reg;
        s_tready   = 1'b0;
        cmd.cmd    = CMD_NOP;
        cmd.op     = mac_op_t'(mi_reg);
        cmd.root   = root_reg;
        cmd.k      = k_reg[SlotW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.cmd    = CMD_LOAD_RAY;
                        k_next     = '0;
                        state_next = ST_SPHERE;
                    end
                    else
                    begin
                        cmd.cmd = CMD_LOAD_SLOT;
                    end
                end
            end
            ST_SPHERE:
            begin
                if (k_reg >= n_lim)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.cmd    = CMD_SEL_SPHERE;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                mi_next    = '0;
                state_next = stat.vis ? ST_MAC_GO : ST_NEXT;
            end
            ST_MAC_GO:
            begin
                cmd.cmd    = CMD_MAC;
                state_next = ST_MAC_WAIT;
            end
            ST_MAC_WAIT:
            begin
                if (stat.mul_done)
                begin
                    if (mi_reg == MacLast)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        mi_next    = mi_reg + 4'd1;
                        state_next = ST_MAC_GO;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.a_zero || stat.disc_neg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.cmd    = CMD_SQRT;
                    state_next = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    root_next  = 1'b0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.cmd    = CMD_DIV;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.cmd = CMD_UPDATE;
                if (root_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    root_next  = 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_NEXT:
            begin
                k_next     = k_reg + CountW'(1);
                state_next = ST_SPHERE;
            end
            ST_FIN:
            begin
                if (!stat.out_full)
                begin
                    cmd.cmd    = CMD_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CRSH_ASSERT_NEXT(a_fin_publish, state_reg == ST_FIN && !stat.out_full, stat.out_full)
    `CRSH_ASSERT_IMP(a_k_bound, 1'b1, k_reg <= CountW'(MaxSpheres))
    `CRSH_ASSERT_IMP(a_mac_wait_busy, state_reg == ST_MAC_WAIT, stat.mul_busy)
    `CRSH_ASSERT_IMP(a_ready_quiet, s_tready, !stat.mul_busy)

endmodule

// ----- design/crsh_dp.sv -----
// Datapath of the closest-hit search: sphere table, serial multiply-accumulate,
// digit square root, restoring divider and nearest-hit register. Depends on crsh_pkg.
module crsh_dp
    import crsh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [InDataW-1:0]   in_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutDataW-1:0]  m_tdata
);

    logic signed [31:0] cx_mem [MaxSpheres];
    logic signed [31:0] cy_mem [MaxSpheres];
    logic signed [31:0] cz_mem [MaxSpheres];
    logic [30:0]        r_mem  [MaxSpheres];
    logic               vis_reg [MaxSpheres];

    logic signed [31:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic signed [31:0] tl_reg, th_reg;
    logic signed [32:0] cox_reg, coy_reg, coz_reg;
    logic [30:0]        rsel_reg;
    logic               vsel_reg;

    logic [63:0]            a_reg;
    logic signed [OpW-1:0]  b_reg, c_reg;
    logic signed [AccW-1:0] disc_reg, acc_reg, acc_new;

    logic [AccW-1:0]  mand_reg, pacc_reg;
    logic [OpW-1:0]   mpl_reg;
    logic             mneg_reg, mbusy_reg;
    mac_op_t          op_reg;

    logic [AccW-1:0]   rad_reg;
    logic [SqRemW-1:0] srem_reg, trem, trial;
    logic [OpW-1:0]    sroot_reg;
    logic [StepW-1:0]  scnt_reg;
    logic              sbusy_reg;

    logic [QW-1:0]      dvd_reg, dq_reg;
    logic [DivRemW-1:0] drem_reg, dtr;
    logic [StepW-1:0]   dcnt_reg;
    logic               dbusy_reg, dneg_reg;
    logic [DenW-1:0]    den;

    logic               found_reg;
    logic [SlotW-1:0]   idx_reg;
    logic signed [31:0] best_reg;
    logic               out_full_reg;
    logic [OutDataW-1:0] out_reg;

    logic signed [OpW-1:0] opa, opb;
    logic                  op_sub, op_clr;
    logic [OpW-1:0]        mag_a, mag_b;
    logic signed [69:0]    num;
    logic [69:0]           num_mag;
    logic                  q_big;
    logic signed [31:0]    t_val;
    logic                  mul_done;

    assign den = {a_reg, 1'b0};

    always_comb
    begin
        opa    = '0;
        opb    = '0;
        op_sub = 1'b0;
        op_clr = 1'b0;
        unique case (cmd.op)
            MAC_DXDX: begin opa = OpW'(dx_reg); opb = OpW'(dx_reg); op_clr = 1'b1; end
            MAC_DYDY: begin opa = OpW'(dy_reg); opb = OpW'(dy_reg); end
            MAC_DZDZ: begin opa = OpW'(dz_reg); opb = OpW'(dz_reg); end
            MAC_CXDX: begin opa = OpW'(cox_reg); opb = OpW'(dx_reg); op_clr = 1'b1; end
            MAC_CYDY: begin opa = OpW'(coy_reg); opb = OpW'(dy_reg); end
            MAC_CZDZ: begin opa = OpW'(coz_reg); opb = OpW'(dz_reg); end
            MAC_CXCX: begin opa = OpW'(cox_reg); opb = OpW'(cox_reg); op_clr = 1'b1; end
            MAC_CYCY: begin opa = OpW'(coy_reg); opb = OpW'(coy_reg); end
            MAC_CZCZ: begin opa = OpW'(coz_reg); opb = OpW'(coz_reg); end
            MAC_RR:
            begin
                opa = OpW'(rsel_reg);
                opb = OpW'(rsel_reg);
                op_sub = 1'b1;
            end
            MAC_BB:   begin opa = b_reg; opb = b_reg; op_clr = 1'b1; end
            MAC_AC4:
            begin
                opa = {2'b00, a_reg, 2'b00};
                opb = c_reg;
                op_sub = 1'b1;
            end
            default:  begin opa = '0; opb = '0; end
        endcase
        mag_a = opa[OpW-1] ? OpW'(-opa) : OpW'(opa);
        mag_b = opb[OpW-1] ? OpW'(-opb) : OpW'(opb);
    end

    assign mul_done = mbusy_reg && (mpl_reg == '0);
    assign acc_new  = mneg_reg ? acc_reg - $signed(pacc_reg) : acc_reg + $signed(pacc_reg);

    assign trem  = {srem_reg[SqRemW-3:0], rad_reg[AccW-1:AccW-2]};
    assign trial = {2'b00, sroot_reg, 2'b01};
    assign dtr   = {drem_reg[DivRemW-2:0], dvd_reg[QW-1]};

    always_comb
    begin
        num = cmd.root ? (-70'(b_reg) - $signed({2'b00, sroot_reg}))
                       : ($signed({2'b00, sroot_reg}) - 70'(b_reg));
        num_mag = num[69] ? 70'(-num) : 70'(num);
        q_big = |dq_reg[QW-1:32];
        if (!dneg_reg)
        begin
            t_val = (q_big || dq_reg[31]) ? 32'sh7FFFFFFF : $signed(dq_reg[31:0]);
        end
        else
        begin
            t_val = (q_big || dq_reg[31:0] > 32'h80000000) ? 32'sh80000000
                                                          : $signed(-dq_reg[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmd == CMD_LOAD_SLOT)
        begin
            cx_mem[in_data[SlotLo +: SlotW]] <= in_data[PosXLo +: 32];
            cy_mem[in_data[SlotLo +: SlotW]] <= in_data[PosYLo +: 32];
            cz_mem[in_data[SlotLo +: SlotW]] <= in_data[PosZLo +: 32];
            r_mem[in_data[SlotLo +: SlotW]]  <= in_data[RadLo +: 31];
        end
        if (cmd.cmd == CMD_LOAD_RAY)
        begin
            ox_reg    <= in_data[PosXLo +: 32];
            oy_reg    <= in_data[PosYLo +: 32];
            oz_reg    <= in_data[PosZLo +: 32];
            dx_reg    <= in_data[DirXLo +: 32];
            dy_reg    <= in_data[DirYLo +: 32];
            dz_reg    <= in_data[DirZLo +: 32];
            tl_reg    <= in_data[TLowLo +: 32];
            th_reg    <= in_data[THighLo +: 32];
            found_reg <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= 32'sh7FFFFFFF;
        end
        if (cmd.cmd == CMD_SEL_SPHERE)
        begin
            cox_reg  <= 33'(ox_reg) - 33'(cx_mem[cmd.k]);
            coy_reg  <= 33'(oy_reg) - 33'(cy_mem[cmd.k]);
            coz_reg  <= 33'(oz_reg) - 33'(cz_mem[cmd.k]);
            rsel_reg <= r_mem[cmd.k];
            vsel_reg <= vis_reg[cmd.k];
        end
        if (cmd.cmd == CMD_MAC)
        begin
            if (op_clr)
            begin
                acc_reg <= '0;
            end
            mand_reg <= AccW'(mag_a);
            mpl_reg  <= mag_b;
            pacc_reg <= '0;
            mneg_reg <= opa[OpW-1] ^ opb[OpW-1] ^ op_sub;
            op_reg   <= cmd.op;
        end
        else if (mbusy_reg)
        begin
            if (mpl_reg != '0)
            begin
                if (mpl_reg[0])
                begin
                    pacc_reg <= pacc_reg + mand_reg;
                end
                mand_reg <= {mand_reg[AccW-2:0], 1'b0};
                mpl_reg  <= {1'b0, mpl_reg[OpW-1:1]};
            end
            else
            begin
                acc_reg <= acc_new;
                unique case (op_reg)
                    MAC_DZDZ: a_reg    <= acc_new[63:0];
                    MAC_CZDZ: b_reg    <= {acc_new[OpW-2:0], 1'b0};
                    MAC_RR:   c_reg    <= acc_new[OpW-1:0];
                    MAC_AC4:  disc_reg <= acc_new;
                    default:  ;
                endcase
            end
        end
        if (cmd.cmd == CMD_SQRT)
        begin
            rad_reg   <= disc_reg;
            srem_reg  <= '0;
            sroot_reg <= '0;
        end
        else if (sbusy_reg && scnt_reg != '0)
        begin
            rad_reg <= {rad_reg[AccW-3:0], 2'b00};
            if (trem >= trial)
            begin
                srem_reg  <= trem - trial;
                sroot_reg <= {sroot_reg[OpW-2:0], 1'b1};
            end
            else
            begin
                srem_reg  <= trem;
                sroot_reg <= {sroot_reg[OpW-2:0], 1'b0};
            end
        end
        if (cmd.cmd == CMD_DIV)
        begin
            dvd_reg  <= {num_mag[OpW-1:0], 16'h0000};
            drem_reg <= '0;
            dq_reg   <= '0;
            dneg_reg <= num[69];
        end
        else if (dbusy_reg && dcnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            if (dtr >= DivRemW'(den))
            begin
                drem_reg <= dtr - DivRemW'(den);
                dq_reg   <= {dq_reg[QW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dtr;
                dq_reg   <= {dq_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.cmd == CMD_UPDATE)
        begin
            if (t_val >= tl_reg && t_val <= th_reg && (!found_reg || t_val < best_reg))
            begin
                found_reg <= 1'b1;
                best_reg  <= t_val;
                idx_reg   <= cmd.k;
            end
        end
        if (cmd.cmd == CMD_PUBLISH)
        begin
            out_reg <= {3'b000, best_reg, idx_reg, found_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxSpheres; i++)
            begin
                vis_reg[i] <= 1'b0;
            end
            mbusy_reg    <= 1'b0;
            sbusy_reg    <= 1'b0;
            scnt_reg     <= '0;
            dbusy_reg    <= 1'b0;
            dcnt_reg     <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cmd == CMD_LOAD_SLOT)
            begin
                vis_reg[in_data[SlotLo +: SlotW]] <= in_data[VisBit];
            end
            if (cmd.cmd == CMD_MAC)
            begin
                mbusy_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                mbusy_reg <= 1'b0;
            end
            if (cmd.cmd == CMD_SQRT)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= StepW'(OpW);
            end
            else if (sbusy_reg)
            begin
                if (scnt_reg == '0)
                begin
                    sbusy_reg <= 1'b0;
                end
                else
                begin
                    scnt_reg <= scnt_reg - StepW'(1);
                end
            end
            if (cmd.cmd == CMD_DIV)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= StepW'(QW);
            end
            else if (dbusy_reg)
            begin
                if (dcnt_reg == '0)
                begin
                    dbusy_reg <= 1'b0;
                end
                else
                begin
                    dcnt_reg <= dcnt_reg - StepW'(1);
                end
            end
            if (cmd.cmd == CMD_PUBLISH)
            begin
                out_full_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    assign stat.vis       = vsel_reg;
    assign stat.mul_busy  = mbusy_reg;
    assign stat.mul_done  = mul_done;
    assign stat.sqrt_done = sbusy_reg && (scnt_reg == '0);
    assign stat.div_done  = dbusy_reg && (dcnt_reg == '0);
    assign stat.a_zero    = (a_reg == '0);
    assign stat.disc_neg  = disc_reg[AccW-1];
    assign stat.out_full  = out_full_reg;

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- design/closest_ray_sphere_hit.sv -----
// Ray-sphere closest-hit search. A load beat writes one of 16 sphere slots.
// A query beat walks slots 0 to min(slot count,16)-1 one at a time: an invisible slot
// is skipped; a visible one runs twelve products through one bit-serial
// multiply-accumulate unit, then, if the direction is nonzero and the discriminant is
// not negative, a square root and two divide-and-test passes.
// The result beat waits in an output register while the next item is taken in.
// Depends on crsh_pkg, crsh_ctrl and crsh_dp.
module closest_ray_sphere_hit
    import crsh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sphere_radius, visible,
    // t_low, t_high, zero fill
    input  logic [InDataW-1:0]   s_tdata,
    // kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit, sphere_index, hit_distance, zero fill
    output logic [OutDataW-1:0]  m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CountW-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    crsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    crsh_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
